@@ rtl/dbpc_pkg.sv @@
// Shared types and constants for the button debounce and press classifier.
package dbpc_pkg;

	localparam int unsigned CntW = 16;
	localparam int unsigned InDataW = 8;
	localparam int unsigned OutDataW = 8;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [CntW-1:0] DebounceReset = 16'd15;
	localparam logic [CntW-1:0] QuickLimitReset = 16'd500;
	localparam logic [CntW-1:0] LongLimitReset = 16'd2000;

	typedef enum logic [CfgIdxW-1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_QUICK_LIMIT = 2'd1,
		REG_LONG_LIMIT = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		EV_NONE = 3'd0,
		EV_PRESS = 3'd1,
		EV_QUICK = 3'd2,
		EV_NORMAL = 3'd3,
		EV_LONG = 3'd4
	} event_t;

	typedef struct packed {
		logic [CntW-1:0] debounce_ms;
		logic [CntW-1:0] quick_limit_ms;
		logic [CntW-1:0] long_limit_ms;
	} cfg_t;

	typedef struct packed {
		event_t event_code;
		logic stable_level;
	} result_t;

	function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
		sat_inc = (&v) ? v : v + CntW'(1);
	endfunction

endpackage

@@ rtl/dbpc_in_stage.sv @@
// Input register stage holding one accepted pin sample.
module dbpc_in_stage (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_pin,
	input  logic advance,
	output logic in_ready,
	output logic valid_s1,
	output logic pin_s1
);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pin_s1 <= in_pin;
		end
	end
endmodule

@@ rtl/dbpc_engine.sv @@
// Debounce and press-timer state with the per-tick update and release classification.
module dbpc_engine (
	input  logic clk,
	input  logic arst_n,
	input  dbpc_pkg::cfg_t cfg,
	input  logic advance,
	input  logic pin,
	output dbpc_pkg::result_t result
);
	import dbpc_pkg::*;

	logic last_raw_q;
	logic [CntW-1:0] bounce_q;
	logic settling_q;
	logic debounced_q;
	logic [CntW-1:0] press_q;

	logic last_raw_n;
	logic [CntW-1:0] bounce_n;
	logic settling_n;
	logic debounced_n;
	logic [CntW-1:0] press_n;
	event_t ev;

	always_comb begin
		press_n = sat_inc(press_q);
		last_raw_n = last_raw_q;
		bounce_n = bounce_q;
		settling_n = settling_q;
		debounced_n = debounced_q;
		ev = EV_NONE;

		if (pin != last_raw_q) begin
			last_raw_n = pin;
			bounce_n = '0;
			settling_n = 1'b1;
		end else if (settling_q) begin
			bounce_n = sat_inc(bounce_q);
		end

		if (settling_n && (bounce_n > cfg.debounce_ms)) begin
			settling_n = 1'b0;
			debounced_n = last_raw_n;
		end

		// The stored debounced level is always the level as of the previous tick.
		if (debounced_n != debounced_q) begin
			if (!debounced_n) begin
				press_n = '0;
				ev = EV_PRESS;
			end else if (press_n <= cfg.quick_limit_ms) begin
				ev = EV_QUICK;
			end else if (press_n >= cfg.long_limit_ms) begin
				ev = EV_LONG;
			end else begin
				ev = EV_NORMAL;
			end
		end
	end

	assign result.event_code = ev;
	assign result.stable_level = debounced_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q <= 1'b0;
			bounce_q <= '0;
			settling_q <= 1'b0;
			debounced_q <= 1'b0;
			press_q <= '0;
		end else if (advance) begin
			last_raw_q <= last_raw_n;
			bounce_q <= bounce_n;
			settling_q <= settling_n;
			debounced_q <= debounced_n;
			press_q <= press_n;
		end
	end
endmodule

@@ rtl/button_debounce_press_classifier_top.sv @@
// Top level of the button debounce and press classifier.
// Each input transaction is one millisecond tick carrying the raw sample of an
// active-low button pin, and each tick yields exactly one output transaction
// with an event code (0 none, 1 press, 2 quick release, 3 normal release,
// 4 long release) and the debounced level. A tick is registered on entry,
// processed by the combinational debounce and press-timer logic, and held in an
// output register; one tick is accepted every cycle while the output side keeps
// up. The user writes the three limits through the cfg port only while the block
// is idle (the block does not enforce this); writes to other indexes are ignored.
module button_debounce_press_classifier_top (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [dbpc_pkg::InDataW-1:0] s_axis_tdata,   // [0] pin_level, [7:1] zero
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [dbpc_pkg::OutDataW-1:0] m_axis_tdata,  // [2:0] event_code, [3] stable_level
	input  logic cfg_wr_en,
	input  logic [dbpc_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [dbpc_pkg::CntW-1:0] cfg_wdata
);
	import dbpc_pkg::*;

	cfg_t cfg_q;
	logic valid_s1;
	logic pin_s1;
	logic advance;
	result_t result;
	logic out_valid_q;
	result_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms <= DebounceReset;
			cfg_q.quick_limit_ms <= QuickLimitReset;
			cfg_q.long_limit_ms <= LongLimitReset;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DEBOUNCE: cfg_q.debounce_ms <= cfg_wdata;
				REG_QUICK_LIMIT: cfg_q.quick_limit_ms <= cfg_wdata;
				REG_LONG_LIMIT: cfg_q.long_limit_ms <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);

	dbpc_in_stage u_in_stage (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_pin(s_axis_tdata[0]),
		.advance(advance),
		.in_ready(s_axis_tready),
		.valid_s1(valid_s1),
		.pin_s1(pin_s1)
	);

	dbpc_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.advance(advance),
		.pin(pin_s1),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {(OutDataW - 4)'(0), out_q.stable_level, out_q.event_code};
endmodule

@@ tb/dbpc_result_check.sv @@
`timescale 1ns / 1ps
// Watches the stream and register ports of the debounce block, predicts each tick and compares.
module dbpc_result_check
	import dbpc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	input  logic [InDataW-1:0] s_axis_tdata,   // [0] pin_level, [7:1] zero
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic [OutDataW-1:0] m_axis_tdata,  // [2:0] event_code, [3] stable_level
	input  logic cfg_wr_en,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CntW-1:0] cfg_wdata,
	output int fail_count,
	output int outstanding,
	output int ticks_checked,
	output logic [4:0] kinds_seen
);

	localparam logic [CntW-1:0] CountMax = {CntW{1'b1}};

	cfg_t limits;
	logic last_pin;
	logic [CntW-1:0] bounce_ms;
	logic change_pending;
	logic stable;
	logic prev_stable;
	logic [CntW-1:0] held_ms;
	int results_seen;
	result_t expected_ticks[$];

	// Debounce and classify one pin sample, advancing the predicted state.
	task automatic classify_tick(input logic pin, output result_t res);
		event_t code;
		code = EV_NONE;
		if (held_ms != CountMax) held_ms = held_ms + 1'b1;
		if (pin != last_pin) begin
			last_pin = pin;
			bounce_ms = '0;
			change_pending = 1'b1;
		end else if (change_pending && bounce_ms != CountMax) begin
			bounce_ms = bounce_ms + 1'b1;
		end
		if (change_pending && bounce_ms > limits.debounce_ms) begin
			change_pending = 1'b0;
			stable = last_pin;
		end
		if (stable != prev_stable) begin
			if (!stable) begin
				held_ms = '0;
				code = EV_PRESS;
			end else if (held_ms <= limits.quick_limit_ms) begin
				code = EV_QUICK;
			end else if (held_ms >= limits.long_limit_ms) begin
				code = EV_LONG;
			end else begin
				code = EV_NORMAL;
			end
			prev_stable = stable;
		end
		res.event_code = code;
		res.stable_level = stable;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		result_t want;
		result_t got;
		if (!arst_n) begin
			limits.debounce_ms = DebounceReset;
			limits.quick_limit_ms = QuickLimitReset;
			limits.long_limit_ms = LongLimitReset;
			last_pin = 1'b0;
			bounce_ms = '0;
			change_pending = 1'b0;
			stable = 1'b0;
			prev_stable = 1'b0;
			held_ms = '0;
			expected_ticks.delete();
			fail_count = 0;
			outstanding = 0;
			ticks_checked = 0;
			results_seen = 0;
			kinds_seen = '0;
		end else begin
			// Retire the output first so that a result can never match a tick
			// accepted at the same edge.
			if (m_axis_tvalid && m_axis_tready) begin
				got.event_code = event_t'(m_axis_tdata[2:0]);
				got.stable_level = m_axis_tdata[3];
				if (expected_ticks.size() == 0) begin
					if (fail_count < 10)
						$display("Result %0d: unexpected transaction, event %0d level %0b",
							results_seen, got.event_code, got.stable_level);
					fail_count++;
				end else begin
					want = expected_ticks.pop_front();
					if (got.event_code !== want.event_code ||
							got.stable_level !== want.stable_level) begin
						if (fail_count < 10)
							$display("Result %0d: expected event %0d level %0b, got event %0d level %0b",
								results_seen, want.event_code, want.stable_level,
								got.event_code, got.stable_level);
						fail_count++;
					end else begin
						ticks_checked++;
						kinds_seen[want.event_code] = 1'b1;
					end
				end
				results_seen++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				classify_tick(s_axis_tdata[0], want);
				expected_ticks.push_back(want);
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_DEBOUNCE: limits.debounce_ms = cfg_wdata;
					REG_QUICK_LIMIT: limits.quick_limit_ms = cfg_wdata;
					REG_LONG_LIMIT: limits.long_limit_ms = cfg_wdata;
					default: ;
				endcase
			end
			outstanding = expected_ticks.size();
		end
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Stimulus and verdict for the button debounce and press classifier.
module tb;
	import dbpc_pkg::*;

	localparam int CycleLimit = 1_000_000;
	localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
	localparam int IdlePercent = 27;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [InDataW-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OutDataW-1:0] m_axis_tdata;
	logic cfg_wr_en;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CntW-1:0] cfg_wdata;

	int fail_count;
	int outstanding;
	int ticks_checked;
	logic [4:0] kinds_seen;

	bit steady = 1'b0;
	int cycle_count = 0;
	int settings_run = 0;
	logic [CntW-1:0] deb_now = DebounceReset;
	logic pin_now = 1'b0;

	button_debounce_press_classifier_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	dbpc_result_check u_tick_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.ticks_checked(ticks_checked),
		.kinds_seen(kinds_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycle_count, outstanding);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready = steady || ($urandom_range(0, 99) >= IdlePercent);
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_tick(input logic pin);
		if (!steady) begin
			while ($urandom_range(0, 99) < IdlePercent) begin
				s_axis_tvalid = 1'b0;
				@(negedge clk);
			end
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {{(InDataW-1){1'b0}}, pin};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		pin_now = pin;
	endtask

	task automatic hold_pin(input logic pin, input int n);
		repeat (n) send_tick(pin);
	endtask

	task automatic drain();
		s_axis_tvalid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CntW-1:0] val);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		if (idx == REG_DEBOUNCE) deb_now = val;
	endtask

	task automatic apply_settings(input logic [CntW-1:0] deb, input logic [CntW-1:0] quick,
			input logic [CntW-1:0] lng);
		drain();
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_QUICK_LIMIT, quick);
		write_reg(REG_LONG_LIMIT, lng);
		settings_run++;
	endtask

	// Alternating pin levels: mostly holds long enough to be accepted, the
	// rest short bounces and bursts of random chatter.
	task automatic random_presses(input int n_items, input int span, input bit with_pause);
		int sent;
		int seg;
		int pick;
		bit paused;
		logic pin;
		sent = 0;
		paused = 1'b0;
		pin = ~pin_now;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				seg = $urandom_range(int'(deb_now) + 1, int'(deb_now) + span);
				hold_pin(pin, seg);
			end else if (pick < 90) begin
				seg = $urandom_range(1, int'(deb_now) + 1);
				hold_pin(pin, seg);
			end else begin
				seg = $urandom_range(1, 6);
				repeat (seg) send_tick(1'($urandom_range(0, 1)));
			end
			sent += seg;
			pin = ~pin_now;
			if (with_pause && !paused && sent >= n_items / 2) begin
				drain();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_DEBOUNCE;
		cfg_wdata = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// A rise right after reset is a release with no press before it; it also
		// exercises the reset values of the debounce time and quick limit.
		hold_pin(1'b1, 17);

		apply_settings(16'd0, 16'd2, 16'd4);
		write_reg(RegUnused, 16'($urandom));
		hold_pin(1'b0, 2);
		hold_pin(1'b1, 2);
		hold_pin(1'b0, 3);
		hold_pin(1'b1, 2);
		hold_pin(1'b0, 4);
		hold_pin(1'b1, 2);
		// The pin dips and comes back before the dip is accepted.
		hold_pin(1'b0, 1);
		hold_pin(1'b1, 2);

		apply_settings(16'd2, 16'd4, 16'd10);
		random_presses(110, 14, 1'b0);
		apply_settings(16'd0, 16'd0, 16'd0);
		random_presses(70, 6, 1'b0);
		// Quick limit above long limit: the quick class takes the overlap.
		apply_settings(16'd3, 16'd8, 16'd4);
		random_presses(90, 16, 1'b0);
		apply_settings(16'd1, 16'hFFFF, 16'hFFFF);
		random_presses(50, 8, 1'b0);
		apply_settings(16'd5, 16'd6, 16'd20);
		random_presses(130, 25, 1'b1);

		steady = 1'b1;
		apply_settings(16'd0, 16'd3, 16'd5);
		random_presses(90, 8, 1'b0);
		// Limits at the top of the range: a short press still classes as quick.
		apply_settings(16'd0, 16'hFFFE, 16'hFFFF);
		hold_pin(1'b0, 10);
		hold_pin(1'b1, 2);
		// With the largest debounce time a held change stays unaccepted.
		apply_settings(16'hFFFF, QuickLimitReset, LongLimitReset);
		hold_pin(1'b0, 20);
		apply_settings(16'd1, QuickLimitReset, LongLimitReset);
		hold_pin(1'b0, 2);
		hold_pin(1'b1, 3);
		steady = 1'b0;

		apply_settings(16'd4, 16'd10, 16'd30);
		random_presses(50, 40, 1'b0);

		s_axis_tvalid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (10) @(negedge clk);

		$display("Checked %0d ticks over %0d register settings, covering bounces, limit overlap",
			ticks_checked, settings_run);
		$display("and limits at the top of the 16-bit range; event codes seen (bit n = code n): %b",
			kinds_seen);
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/dbpc_pkg.sv
rtl/dbpc_in_stage.sv
rtl/dbpc_engine.sv
rtl/button_debounce_press_classifier_top.sv
tb/dbpc_result_check.sv
tb/tb.sv
